// ===== design/mns_pkg.sv =====
// package: shared types, widths and constants of the melody note sequencer
`default_nettype none

package mns_pkg;

  localparam int unsigned NoteDepthDef = 256;
  localparam int unsigned IdxW = 8;
  localparam int unsigned LenW = 15;
  localparam int unsigned DivW = 16;
  localparam int unsigned CmpW = 15;
  localparam logic [DivW-1:0] PeriodReset = DivW'(1000);

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_PLAY  = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_TONE  = 3'd3,
    CMD_WRITE = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [DivW-1:0] div;
  } note_t;

endpackage

`default_nettype wire

// ===== design/mns_in_if.sv =====
// interface: command item channel into the sequencer
`default_nettype none

interface mns_in_if
  import mns_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [2:0]      command;
  logic [IdxW-1:0] note_index;
  logic [LenW-1:0] note_length;
  logic [DivW-1:0] note_divider;

  modport source (output valid, command, note_index, note_length, note_divider, input ready);
  modport sink (input valid, command, note_index, note_length, note_divider, output ready);
endinterface

`default_nettype wire

// ===== design/mns_out_if.sv =====
// interface: tone status item channel out of the sequencer
`default_nettype none

interface mns_out_if
  import mns_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            tone_on;
  logic [DivW-1:0] tone_period;
  logic [CmpW-1:0] tone_compare;
  logic            busy_res;

  modport source (output valid, tone_on, tone_period, tone_compare, busy_res, input ready);
  modport sink (input valid, tone_on, tone_period, tone_compare, busy_res, output ready);
endinterface

`default_nettype wire

// ===== design/melody_note_sequencer_top.sv =====
// top level: tick-driven melody player over a note store
`default_nettype none

// Accepts one command item per cycle unless the output stalls, and returns one status
// item for each via the input, then the result register. The note store is a single
// memory with one write and one registered read port; the read always fetches the note
// that the next tick would load, and a write to that same entry is forwarded, so loads
// never stall. Entries must be written before a melody reaches them.
module melody_note_sequencer_top
  import mns_pkg::*;
#(
  parameter int unsigned NOTE_DEPTH = NoteDepthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  mns_in_if.sink     in_i,
  mns_out_if.source  out_o
);

  localparam int unsigned AddrW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int unsigned NumIdx = 1 << IdxW;

  function automatic logic [NumIdx*AddrW-1:0] build_idx_mod();
    logic [NumIdx*AddrW-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < NumIdx; i++) begin
      tbl[i*AddrW +: AddrW] = AddrW'(i % NOTE_DEPTH);
    end
    return tbl;
  endfunction

  localparam logic [NumIdx*AddrW-1:0] IdxMod = build_idx_mod();

  // input register
  logic            inq_valid_q;
  logic [2:0]      inq_cmd_q;
  logic [IdxW-1:0] inq_idx_q;
  logic [LenW-1:0] inq_len_q;
  logic [DivW-1:0] inq_div_q;

  // result register
  logic            res_valid_q;
  logic            res_on_q;
  logic [DivW-1:0] res_period_q;
  logic [CmpW-1:0] res_cmp_q;
  logic            res_busy_q;

  // player state
  logic [LenW-1:0]  rem_q, rem_d;
  logic             sp_q, sp_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] ns_q, ns_d;
  logic [DivW-1:0]  period_q, period_d;
  logic             oe_q, oe_d;

  // note store and prefetch
  note_t            mem [NOTE_DEPTH];
  note_t            rd_q;
  logic             fwd_q;
  note_t            fwd_data_q;
  note_t            entry;
  logic [AddrW-1:0] pf_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  note_t            wr_data;

  logic advance;
  logic in_fire;

  assign advance  = inq_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !inq_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  assign entry   = fwd_q ? fwd_data_q : rd_q;
  assign wr_addr = IdxMod[inq_idx_q*AddrW +: AddrW];
  assign wr_data = '{len: inq_len_q, div: inq_div_q};

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    return (p == AddrW'(NOTE_DEPTH - 1)) ? '0 : p + AddrW'(1);
  endfunction

  always_comb begin
    logic load;
    logic [AddrW-1:0] load_addr;
    rem_d     = rem_q;
    sp_d      = sp_q;
    ptr_d     = ptr_q;
    ns_d      = ns_q;
    period_d  = period_q;
    oe_d      = oe_q;
    wr_en     = 1'b0;
    load      = 1'b0;
    load_addr = ptr_inc(ptr_q);
    if (advance) begin
      unique case (inq_cmd_q)
        CMD_TICK: begin
          if (sp_q) begin
            sp_d      = 1'b0;
            load      = 1'b1;
            load_addr = ns_q;
          end else if (rem_q != '0) begin
            rem_d = rem_q - LenW'(1);
            load  = (rem_q == LenW'(1));
          end
        end
        CMD_PLAY: begin
          ns_d = wr_addr;
          sp_d = 1'b1;
        end
        CMD_STOP: begin
          rem_d = '0;
          sp_d  = 1'b0;
          oe_d  = 1'b0;
        end
        CMD_TONE: begin
          period_d = inq_div_q;
          oe_d     = 1'b1;
        end
        CMD_WRITE: wr_en = 1'b1;
        default: ;
      endcase
      if (load) begin
        ptr_d = load_addr;
        rem_d = entry.len;
        if (entry.len == '0 || entry.div == '0) begin
          oe_d = 1'b0;
        end else begin
          period_d = entry.div;
          oe_d     = 1'b1;
        end
      end
    end
    pf_addr = sp_d ? ns_d : ptr_inc(ptr_d);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q       <= mem[pf_addr];
    fwd_q      <= wr_en && (wr_addr == pf_addr);
    fwd_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      rem_q       <= '0;
      sp_q        <= 1'b0;
      ptr_q       <= '0;
      ns_q        <= '0;
      period_q    <= PeriodReset;
      oe_q        <= 1'b0;
    end else begin
      if (in_i.ready) begin
        inq_valid_q <= in_i.valid;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
      rem_q    <= rem_d;
      sp_q     <= sp_d;
      ptr_q    <= ptr_d;
      ns_q     <= ns_d;
      period_q <= period_d;
      oe_q     <= oe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_cmd_q <= in_i.command;
      inq_idx_q <= in_i.note_index;
      inq_len_q <= in_i.note_length;
      inq_div_q <= in_i.note_divider;
    end
    if (advance) begin
      res_on_q     <= oe_d;
      res_period_q <= period_d;
      res_cmp_q    <= period_d[DivW-1:1];
      res_busy_q   <= sp_d || (rem_d != '0);
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.tone_on      = res_on_q;
  assign out_o.tone_period  = res_period_q;
  assign out_o.tone_compare = res_cmp_q;
  assign out_o.busy_res     = res_busy_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench: drives command items into the melody note sequencer and checks every tone status item
`timescale 1ns / 100ps

module tb;
  import mns_pkg::*;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_UNUSED = 3'd7;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 75;

  typedef struct packed {
    logic            on;
    logic [DivW-1:0] period;
    logic [CmpW-1:0] cmp;
    logic            busy;
  } tone_status_t;

  class tone_status_board;
    note_t           notes[NoteDepthDef];
    logic [LenW-1:0] ticks_left;
    logic            start_armed;
    logic [IdxW-1:0] play_ptr;
    logic [IdxW-1:0] start_idx;
    logic [DivW-1:0] period;
    logic            tone_en;
    tone_status_t    expected_status[$];
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     note_loads;

    function new();
      ticks_left   = '0;
      start_armed  = 1'b0;
      play_ptr     = '0;
      start_idx    = '0;
      period       = PeriodReset;
      tone_en      = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      note_loads   = 0;
    endfunction

    function void load_entry(logic [IdxW-1:0] idx);
      play_ptr   = idx;
      ticks_left = notes[idx].len;
      note_loads++;
      if (notes[idx].len == '0 || notes[idx].div == '0) begin
        tone_en = 1'b0;
      end else begin
        period  = notes[idx].div;
        tone_en = 1'b1;
      end
    endfunction

    function void predict_status(logic [2:0] c, logic [IdxW-1:0] idx,
                                 logic [LenW-1:0] len, logic [DivW-1:0] div);
      tone_status_t exp_st;
      case (c)
        CMD_TICK: begin
          if (start_armed) begin
            start_armed = 1'b0;
            load_entry(start_idx);
          end else if (ticks_left != '0) begin
            ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) load_entry(IdxW'(play_ptr + 1'b1));
          end
        end
        CMD_PLAY: begin
          start_idx   = idx;
          start_armed = 1'b1;
        end
        CMD_STOP: begin
          ticks_left  = '0;
          start_armed = 1'b0;
          tone_en     = 1'b0;
        end
        CMD_TONE: begin
          period  = div;
          tone_en = 1'b1;
        end
        CMD_WRITE: begin
          notes[idx].len = len;
          notes[idx].div = div;
        end
        default: ;
      endcase
      exp_st.on     = tone_en;
      exp_st.period = period;
      exp_st.cmp    = period[DivW-1:1];
      exp_st.busy   = start_armed || (ticks_left != '0);
      expected_status.push_back(exp_st);
    endfunction

    function void check_status(tone_status_t got);
      tone_status_t exp_st;
      results_seen++;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status item with none expected: on=%0b period=%0d cmp=%0d busy=%0b",
                   $time, got.on, got.period, got.cmp, got.busy);
        return;
      end
      exp_st = expected_status.pop_front();
      if (got.on !== exp_st.on || got.period !== exp_st.period ||
          got.cmp !== exp_st.cmp || got.busy !== exp_st.busy) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: status mismatch: expected on=%0b period=%0d cmp=%0d busy=%0b",
                   $time, exp_st.on, exp_st.period, exp_st.cmp, exp_st.busy);
          $display("%0t: status mismatch: got      on=%0b period=%0d cmp=%0d busy=%0b",
                   $time, got.on, got.period, got.cmp, got.busy);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mns_in_if  cmd_if ();
  mns_out_if status_if ();

  melody_note_sequencer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (status_if)
  );

  tone_status_board board = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver side: random back-pressure plus one long hold
  initial begin
    status_if.ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        status_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      status_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (status_if.valid === 1'b1 && status_if.ready === 1'b1) begin
      board.check_status(tone_status_t'{status_if.tone_on, status_if.tone_period,
                                        status_if.tone_compare, status_if.busy_res});
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
        (status_if.valid === 1'b1 && status_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [2:0] c, input logic [IdxW-1:0] idx,
                          input logic [LenW-1:0] len, input logic [DivW-1:0] div);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= c;
    cmd_if.note_index   <= idx;
    cmd_if.note_length  <= len;
    cmd_if.note_divider <= div;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    board.predict_status(c, idx, len, div);
    items_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [LenW-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 97) return LenW'($urandom_range(4, 1));
    return LenW'($urandom_range(32767, 5));
  endfunction

  function automatic logic [DivW-1:0] rand_div();
    if ($urandom_range(99) < 20) return '0;
    return DivW'($urandom_range(65535, 1));
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned r;
    logic [2:0]  c;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 50) c = CMD_TICK;
      else if (r < 62) c = CMD_PLAY;
      else if (r < 67) c = CMD_STOP;
      else if (r < 75) c = CMD_TONE;
      else if (r < 94) c = CMD_WRITE;
      else c = 3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
      send_cmd(c, IdxW'($urandom_range(255)), rand_len(), rand_div());
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = CMD_TICK;
    cmd_if.note_index   = '0;
    cmd_if.note_length  = '0;
    cmd_if.note_divider = '0;
    tx_idle_pct         = 6;
    rx_idle_pct         = 60;
    hold_req            = 1'b0;
    items_sent          = 0;
    quiet_cycles        = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // idle tick, unknown codes, direct tones at the divider extremes
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_FIRST_UNUSED, 8'hff, 15'h7fff, 16'hffff);
    send_cmd(CMD_LAST_UNUSED, '0, '0, '0);
    send_cmd(CMD_TONE, '0, '0, 16'h0000);
    send_cmd(CMD_TONE, 8'hff, 15'h7fff, 16'hffff);
    send_cmd(CMD_STOP, '0, '0, '0);
    // short melody across the top of the store: tone, rest, wrap, end
    send_cmd(CMD_WRITE, 8'd254, 15'd2, 16'd1);
    send_cmd(CMD_WRITE, 8'd255, 15'd1, 16'd0);
    send_cmd(CMD_WRITE, 8'd0, 15'd1, 16'hffff);
    send_cmd(CMD_WRITE, 8'd1, 15'd0, 16'd1234);
    send_cmd(CMD_PLAY, 8'd254, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_PLAY, 8'd255, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    // longest note, cut short by stop
    send_cmd(CMD_WRITE, 8'd2, 15'h7fff, 16'haaaa);
    send_cmd(CMD_PLAY, 8'd2, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);
    send_cmd(CMD_STOP, '0, '0, '0);
    send_cmd(CMD_TICK, '0, '0, '0);

    // fill the whole store so random plays never reach an unwritten entry
    for (int i = 0; i < NoteDepthDef; i++) begin
      send_cmd(CMD_WRITE, IdxW'(i), rand_len(), rand_div());
    end

    run_random(PHASE_ITEMS);
    wait_all_results();

    tx_idle_pct = 60;
    rx_idle_pct = 6;
    run_random(PHASE_ITEMS);
    wait_all_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random(PHASE_ITEMS);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d command items, %0d status items and %0d note loads",
             items_sent, board.results_seen, board.note_loads);
    $display("under alternating sender/receiver idling, one long output hold and full drains");
    if (board.mismatches == 0 && board.expected_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
